### sv/mvt_pkg.sv
// Shared types, constants and helper functions for the 4x4 float32 transform.
package mvt_pkg;

  localparam int unsigned FmaLat   = 6;
  localparam int unsigned NumRows  = 4;
  localparam int unsigned NumPairs = 8;
  localparam int unsigned CfgIdxW  = 8;

  localparam logic [31:0] QNanDflt = 32'h7FC0_0000;
  localparam logic [31:0] NegZero  = 32'h8000_0000;
  localparam logic [31:0] InfBits  = 32'h7F80_0000;

  localparam logic [63:0] CoefRst [NumPairs] = '{
    64'h0000_0000_3F80_0000, 64'h0,
    64'h3F80_0000_0000_0000, 64'h0,
    64'h0,                   64'h0000_0000_3F80_0000,
    64'h0,                   64'h3F80_0000_0000_0000
  };

  typedef struct packed {
    logic [31:0] comp_x;
    logic [31:0] comp_y;
    logic [31:0] comp_z;
    logic [31:0] comp_w;
    logic        last_in;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] res_x;
    logic [31:0] res_y;
    logic [31:0] res_z;
    logic [31:0] res_w;
    logic        last_out;
  } out_beat_t;

  // leading zero counts (priority encoders)
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       hit;
    n   = 6'd48;
    hit = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (v[i] && !hit) begin
        n   = 6'(47 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       hit;
    n   = 5'd24;
    hit = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (v[i] && !hit) begin
        n   = 5'(23 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc58(input logic [57:0] v);
    logic [5:0] n;
    logic       hit;
    n   = 6'd58;
    hit = 1'b0;
    for (int i = 57; i >= 0; i--) begin
      if (v[i] && !hit) begin
        n   = 6'(57 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // right shift keeping a sticky bit in bit 0
  function automatic logic [56:0] shr_sticky(input logic [56:0] v, input logic [10:0] d);
    logic [56:0] r;
    logic [56:0] msk;
    if (d == 11'd0) begin
      r = v;
    end else if (d >= 11'd57) begin
      r = {56'd0, |v};
    end else begin
      msk = ~({57{1'b1}} << d[5:0]);
      r   = (v >> d[5:0]) | {56'd0, |(v & msk)};
    end
    return r;
  endfunction

endpackage

### sv/mvt_fma.sv
// Six-stage single-precision fused multiply-add, round to nearest even.
module mvt_fma import mvt_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  output logic [31:0] r_o
);

  // ---- stage 1: unpack, specials, mantissa product
  logic       sa, sb, sc, sp;
  logic [7:0] ea, eb, ec;
  logic [22:0] fa, fb, fc;
  logic       az, bz, cz, nan_a, nan_b, nan_c;
  logic       s1_spec;
  logic [31:0] s1_val;
  logic [23:0] ma, mb, mc;

  assign sa = a_i[31];
  assign sb = b_i[31];
  assign sc = c_i[31];
  assign sp = sa ^ sb;
  assign ea = a_i[30:23];
  assign eb = b_i[30:23];
  assign ec = c_i[30:23];
  assign fa = a_i[22:0];
  assign fb = b_i[22:0];
  assign fc = c_i[22:0];
  assign az = (ea == 8'd0) && (fa == 23'd0);
  assign bz = (eb == 8'd0) && (fb == 23'd0);
  assign cz = (ec == 8'd0) && (fc == 23'd0);
  assign nan_a = (ea == 8'hFF) && (fa != 23'd0);
  assign nan_b = (eb == 8'hFF) && (fb != 23'd0);
  assign nan_c = (ec == 8'hFF) && (fc != 23'd0);
  assign ma = {(ea != 8'd0), fa};
  assign mb = {(eb != 8'd0), fb};
  assign mc = {(ec != 8'd0), fc};

  always_comb begin
    s1_spec = 1'b1;
    s1_val  = '0;
    if (nan_a) begin
      s1_val = a_i | 32'h0040_0000;
    end else if (nan_b) begin
      s1_val = b_i | 32'h0040_0000;
    end else if (nan_c) begin
      s1_val = c_i | 32'h0040_0000;
    end else if (ea == 8'hFF || eb == 8'hFF) begin
      if (az || bz) begin
        s1_val = QNanDflt;
      end else if (ec == 8'hFF && sc != sp) begin
        s1_val = QNanDflt;
      end else begin
        s1_val = {sp, InfBits[30:0]};
      end
    end else if (ec == 8'hFF) begin
      s1_val = c_i;
    end else if (az || bz) begin
      s1_val = cz ? {sp & sc, 31'd0} : c_i;
    end else begin
      s1_spec = 1'b0;
    end
  end

  logic        s1_spec_q, s1_sp_q, s1_sc_q, s1_cz_q;
  logic [31:0] s1_val_q;
  logic [47:0] s1_p_q;
  logic [8:0]  s1_eab_q;
  logic [7:0]  s1_ec_q;
  logic [23:0] s1_mc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_spec_q <= s1_spec;
      s1_val_q  <= s1_val;
      s1_sp_q   <= sp;
      s1_sc_q   <= sc;
      s1_cz_q   <= cz;
      s1_p_q    <= ma * mb;
      s1_eab_q  <= 9'((ea == 8'd0) ? 8'd1 : ea) + 9'((eb == 8'd0) ? 8'd1 : eb);
      s1_ec_q   <= (ec == 8'd0) ? 8'd1 : ec;
      s1_mc_q   <= mc;
    end
  end

  // ---- stage 2: normalise product and addend
  logic [5:0]  lzp;
  logic [4:0]  lzc_c;
  logic [56:0] s2_x, s2_y;
  logic signed [10:0] s2_ex, s2_ey;

  assign lzp   = lzc48(s1_p_q);
  assign lzc_c = lzc24(s1_mc_q);
  assign s2_x  = {s1_p_q, 9'd0} << lzp;
  assign s2_y  = {s1_mc_q, 33'd0} << lzc_c;
  assign s2_ex = $signed(11'(s1_eab_q)) - 11'sd309 - $signed(11'(lzp));
  assign s2_ey = $signed(11'(s1_ec_q)) - 11'sd183 - $signed(11'(lzc_c));

  logic        s2_spec_q, s2_sp_q, s2_sc_q, s2_cz_q;
  logic [31:0] s2_val_q;
  logic [56:0] s2_x_q, s2_y_q;
  logic signed [10:0] s2_ex_q, s2_ey_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_spec_q <= s1_spec_q;
      s2_val_q  <= s1_val_q;
      s2_sp_q   <= s1_sp_q;
      s2_sc_q   <= s1_sc_q;
      s2_cz_q   <= s1_cz_q;
      s2_x_q    <= s2_x;
      s2_y_q    <= s2_y;
      s2_ex_q   <= s2_ex;
      s2_ey_q   <= s2_ey;
    end
  end

  // ---- stage 3: align the smaller operand
  logic [56:0] s3_x, s3_y;
  logic signed [10:0] s3_e;
  logic signed [11:0] diff;

  assign diff = 12'(s2_ex_q) - 12'(s2_ey_q);

  always_comb begin
    s3_x = s2_x_q;
    s3_y = s2_y_q;
    s3_e = s2_ex_q;
    if (s2_cz_q) begin
      s3_y = '0;
    end else if (!diff[11]) begin
      s3_y = shr_sticky(s2_y_q, diff[10:0]);
    end else begin
      s3_x = shr_sticky(s2_x_q, 11'(-diff));
      s3_e = s2_ey_q;
    end
  end

  logic        s3_spec_q, s3_sp_q, s3_sc_q;
  logic [31:0] s3_val_q;
  logic [56:0] s3_x_q, s3_y_q;
  logic signed [10:0] s3_e_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_spec_q <= s2_spec_q;
      s3_val_q  <= s2_val_q;
      s3_sp_q   <= s2_sp_q;
      s3_sc_q   <= s2_sc_q;
      s3_x_q    <= s3_x;
      s3_y_q    <= s3_y;
      s3_e_q    <= s3_e;
    end
  end

  // ---- stage 4: add or subtract magnitudes
  logic [57:0] s4_s;
  logic        s4_sign;

  always_comb begin
    if (s3_sp_q == s3_sc_q) begin
      s4_s    = 58'(s3_x_q) + 58'(s3_y_q);
      s4_sign = s3_sp_q;
    end else if (s3_x_q >= s3_y_q) begin
      s4_s    = 58'(s3_x_q) - 58'(s3_y_q);
      s4_sign = s3_sp_q;
    end else begin
      s4_s    = 58'(s3_y_q) - 58'(s3_x_q);
      s4_sign = s3_sc_q;
    end
  end

  logic        s4_spec_q, s4_sign_q;
  logic [31:0] s4_val_q;
  logic [57:0] s4_s_q;
  logic signed [10:0] s4_e_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_spec_q <= s3_spec_q;
      s4_val_q  <= s3_val_q;
      s4_sign_q <= s4_sign;
      s4_s_q    <= s4_s;
      s4_e_q    <= s3_e_q;
    end
  end

  // ---- stage 5: find the top bit, pick shift incl. subnormal limit
  logic [5:0] s5_t;
  logic signed [10:0] s5_sh, s5_lim, s5_f;
  logic       s5_zero;

  assign s5_zero = (s4_s_q == 58'd0);
  assign s5_t    = 6'd57 - lzc58(s4_s_q);
  assign s5_lim  = -11'sd149 - s4_e_q;

  always_comb begin
    s5_sh = $signed(11'(s5_t)) - 11'sd23;
    if (s5_sh < s5_lim) begin
      s5_sh = s5_lim;
    end
    s5_f = s4_e_q + s5_sh + 11'sd150;
  end

  logic        s5_spec_q, s5_sign_q;
  logic [31:0] s5_val_q;
  logic [57:0] s5_s_q;
  logic signed [10:0] s5_sh_q, s5_f_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // exact cancellation gives +0
      s5_spec_q <= s4_spec_q || s5_zero;
      s5_val_q  <= s4_spec_q ? s4_val_q : 32'd0;
      s5_sign_q <= s4_sign_q;
      s5_s_q    <= s4_s_q;
      s5_sh_q   <= s5_sh;
      s5_f_q    <= s5_f;
    end
  end

  // ---- stage 6: round and pack
  logic [57:0] shifted, below;
  logic [24:0] s6_m;
  logic [31:0] s6_bits, s6_res;
  logic [5:0]  shr;
  logic        guard, stk;

  assign shr = s5_sh_q[5:0];

  always_comb begin
    shifted = '0;
    below   = '0;
    guard   = 1'b0;
    stk     = 1'b0;
    s6_m    = '0;
    if (s5_sh_q <= 11'sd0) begin
      shifted = s5_s_q << 6'(-s5_sh_q);
      s6_m    = shifted[24:0];
    end else if (s5_sh_q < 11'sd59) begin
      shifted = s5_s_q >> shr;
      guard   = s5_s_q[shr - 6'd1];
      below   = s5_s_q & ~({58{1'b1}} << (shr - 6'd1));
      stk     = (below != 58'd0);
      s6_m    = shifted[24:0] + 25'(guard && (stk || shifted[0]));
    end
    s6_bits = ({24'(s5_f_q[7:0] - 8'd1), 8'd0} << 15) + 32'(s6_m);
    if (s5_f_q > 11'sd254 || s6_bits >= InfBits) begin
      s6_res = {s5_sign_q, InfBits[30:0]};
    end else begin
      s6_res = {s5_sign_q, s6_bits[30:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_o <= s5_spec_q ? s5_val_q : s6_res;
    end
  end

endmodule

### sv/mvt_lane.sv
// One matrix row: chain of four fused multiply-adds, w term first.
module mvt_lane import mvt_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] coef_i [4],
  input  logic [31:0] w_i,
  input  logic [31:0] z_i,
  input  logic [31:0] y_i,
  input  logic [31:0] x_i,
  output logic [31:0] res_o
);

  logic [31:0] acc0, acc1, acc2;

  mvt_fma u_fma_w (.clk_i, .en_i, .a_i(coef_i[3]), .b_i(w_i), .c_i(NegZero), .r_o(acc0));
  mvt_fma u_fma_z (.clk_i, .en_i, .a_i(coef_i[2]), .b_i(z_i), .c_i(acc0),    .r_o(acc1));
  mvt_fma u_fma_y (.clk_i, .en_i, .a_i(coef_i[1]), .b_i(y_i), .c_i(acc1),    .r_o(acc2));
  mvt_fma u_fma_x (.clk_i, .en_i, .a_i(coef_i[0]), .b_i(x_i), .c_i(acc2),    .r_o(res_o));

endmodule

### sv/mat4_vec4_transform.sv
// Each input beat is computed through four 6-stage FMAs in a chain, then the output register.
// Throughput: one vector per cycle while the output is not stalled; four row lanes run side by side.
// A stalled output beat freezes the whole pipeline, so input stall follows it.
// Reset (async, active low) clears pipeline valids and loads the identity matrix.
// Coefficient writes are taken every cycle; indexes beyond 7 are dropped.
module mat4_vec4_transform import mvt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_beat_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_beat_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [63:0]         cfg_data_i
);

  localparam int unsigned Depth = NumRows * FmaLat;

  logic [63:0] coef_q [NumPairs];
  logic        en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= CoefRst;
    end else if (cfg_valid_i && cfg_index_i < CfgIdxW'(NumPairs)) begin
      coef_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // valid/last tracking and operand delay lines
  logic [Depth-1:0] vld_q;
  logic [Depth-1:0] last_q;
  logic [31:0] z_q [FmaLat];
  logic [31:0] y_q [2*FmaLat];
  logic [31:0] x_q [3*FmaLat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q <= {last_q[Depth-2:0], in_data_i.last_in};
      z_q[0] <= in_data_i.comp_z;
      y_q[0] <= in_data_i.comp_y;
      x_q[0] <= in_data_i.comp_x;
      for (int i = 1; i < FmaLat; i++) z_q[i] <= z_q[i-1];
      for (int i = 1; i < 2*FmaLat; i++) y_q[i] <= y_q[i-1];
      for (int i = 1; i < 3*FmaLat; i++) x_q[i] <= x_q[i-1];
    end
  end

  logic [31:0] lane_res [NumRows];

  for (genvar r = 0; r < NumRows; r++) begin : g_lane
    logic [31:0] row_coef [4];
    assign row_coef[0] = coef_q[2*r][31:0];
    assign row_coef[1] = coef_q[2*r][63:32];
    assign row_coef[2] = coef_q[2*r+1][31:0];
    assign row_coef[3] = coef_q[2*r+1][63:32];

    mvt_lane u_lane (
      .clk_i,
      .en_i  (en),
      .coef_i(row_coef),
      .w_i   (in_data_i.comp_w),
      .z_i   (z_q[FmaLat-1]),
      .y_i   (y_q[2*FmaLat-1]),
      .x_i   (x_q[3*FmaLat-1]),
      .res_o (lane_res[r])
    );
  end

  // merge lanes into the output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_o.res_x    <= lane_res[0];
      out_data_o.res_y    <= lane_res[1];
      out_data_o.res_z    <= lane_res[2];
      out_data_o.res_w    <= lane_res[3];
      out_data_o.last_out <= last_q[Depth-1];
    end
  end

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Depth-1] && en |=> out_valid_o)
    else $error("finished vector not presented");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while output stalled");

  a_nodup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !vld_q[Depth-1] |=> !out_valid_o)
    else $error("output beat repeated");

endmodule
